@@ rtl/core/glcn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcn_pkg
// Types and constants shared by the grouped L1 command normalizer: command
// format, beat payloads and the per-lane state carried down the divider.
// ----------------------------------------------------------------------------
package glcn_pkg;

  localparam int CMD_W    = 16;  // command width, two's complement
  localparam int FRAC_W   = 12;  // fraction bits, so 1.0 is 2**FRAC_W
  localparam int NUM_CMDS = 6;

  // A group sum of three magnitudes is at most 3 * 2**(CMD_W-1).
  localparam int SUM_W  = CMD_W + 2;
  // A member never exceeds its group sum, so the quotient is at most 1.0.
  localparam int QUO_W  = FRAC_W + 1;
  localparam int WIDE_W = ((QUO_W + 1 > CMD_W) ? QUO_W + 1 : CMD_W) + 1;

  localparam logic [SUM_W-1:0] ONE_SUM = SUM_W'(longint'(1) << FRAC_W);
  localparam logic [QUO_W-1:0] ONE_QUO = QUO_W'(longint'(1) << FRAC_W);

  // Lane positions inside the internal command arrays.
  localparam int LANE_YAW   = 0;
  localparam int LANE_ROLL  = 1;
  localparam int LANE_PITCH = 2;
  localparam int LANE_X     = 3;
  localparam int LANE_Y     = 4;
  localparam int LANE_Z     = 5;

  // Group codes; bit i of ATT_LANES is set when lane i is in the attitude group.
  localparam int GRP_PLANAR = 0;
  localparam int GRP_ATT    = 1;
  localparam logic [NUM_CMDS-1:0] ATT_LANES = 6'b100110;

  typedef logic signed [CMD_W-1:0]  cmd_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam wide_t SAT_MAX = wide_t'((longint'(1) << (CMD_W - 1)) - 1);
  localparam wide_t SAT_MIN = wide_t'(-(longint'(1) << (CMD_W - 1)));

  typedef struct packed {
    cmd_t yaw_cmd;
    cmd_t roll_cmd;
    cmd_t pitch_cmd;
    cmd_t x_cmd;
    cmd_t y_cmd;
    cmd_t z_cmd;
  } cmd_in_t;

  typedef struct packed {
    cmd_t yaw_out;
    cmd_t roll_out;
    cmd_t pitch_out;
    cmd_t x_out;
    cmd_t y_out;
    cmd_t z_out;
  } cmd_out_t;

  typedef struct packed {
    cmd_t              raw;  // original command, passed when no scaling
    logic [SUM_W-1:0]  rem;  // partial remainder of the division
    logic [QUO_W-1:0]  quo;  // quotient bits developed so far
  } lane_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             zero;
    logic             over;  // sum exceeds 1.0, scaling applies
  } grp_t;

  typedef struct packed {
    lane_t [NUM_CMDS-1:0] lane;
    grp_t  [1:0]          grp;
  } work_t;

endpackage

@@ rtl/core/glcn_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcn_front
// Three pipeline stages: magnitudes, group sums with their flags, and the
// leading quotient bit of every lane.
// ----------------------------------------------------------------------------
module glcn_front import glcn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  logic    valid_i,
  input  cmd_in_t data_i,
  output logic    valid_o,
  output work_t   work_o
);

  cmd_t             cmd [NUM_CMDS];
  cmd_t             raw1_q [NUM_CMDS];
  logic [CMD_W-1:0] mag1_q [NUM_CMDS];
  cmd_t             raw2_q [NUM_CMDS];
  logic [CMD_W-1:0] mag2_q [NUM_CMDS];
  grp_t             grp_d [2];
  grp_t             grp2_q [2];
  logic [SUM_W-1:0] sum [2];
  work_t            work_d;
  work_t            work_q;
  logic             v1_q, v2_q, v3_q;

  assign cmd[LANE_YAW]   = data_i.yaw_cmd;
  assign cmd[LANE_ROLL]  = data_i.roll_cmd;
  assign cmd[LANE_PITCH] = data_i.pitch_cmd;
  assign cmd[LANE_X]     = data_i.x_cmd;
  assign cmd[LANE_Y]     = data_i.y_cmd;
  assign cmd[LANE_Z]     = data_i.z_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: magnitude. The most negative code maps to 2**(CMD_W-1), which
  // still fits as an unsigned value of the same width.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int i = 0; i < NUM_CMDS; i++) begin
        raw1_q[i] <= cmd[i];
        mag1_q[i] <= cmd[i][CMD_W-1] ? (~cmd[i] + 1'b1) : cmd[i];
      end
    end
  end

  // Stage 2: group sums.
  always_comb begin
    sum[GRP_PLANAR] = SUM_W'(mag1_q[LANE_YAW]) + SUM_W'(mag1_q[LANE_X])
                    + SUM_W'(mag1_q[LANE_Y]);
    sum[GRP_ATT]    = SUM_W'(mag1_q[LANE_ROLL]) + SUM_W'(mag1_q[LANE_PITCH])
                    + SUM_W'(mag1_q[LANE_Z]);
    for (int g = 0; g < 2; g++) begin
      grp_d[g].sum  = sum[g];
      grp_d[g].zero = (sum[g] == '0);
      grp_d[g].over = (sum[g] > ONE_SUM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      raw2_q <= raw1_q;
      mag2_q <= mag1_q;
      grp2_q <= grp_d;
    end
  end

  // Stage 3: leading quotient bit, set only when the member equals its sum.
  always_comb begin
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] m;
    logic             ge;
    s  = '0;
    m  = '0;
    ge = 1'b0;
    work_d = '0;
    for (int g = 0; g < 2; g++) begin
      work_d.grp[g] = grp2_q[g];
    end
    for (int i = 0; i < NUM_CMDS; i++) begin
      s  = grp2_q[ATT_LANES[i]].sum;
      m  = SUM_W'(mag2_q[i]);
      ge = (m >= s);
      work_d.lane[i].raw = raw2_q[i];
      work_d.lane[i].rem = ge ? (m - s) : m;
      work_d.lane[i].quo = QUO_W'(ge);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = v3_q;
  assign work_o  = work_q;

endmodule

@@ rtl/core/glcn_div_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcn_div_step
// One restoring division stage: develops one quotient bit for all six lanes
// against their group sums and registers the result.
// ----------------------------------------------------------------------------
module glcn_div_step import glcn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  advance_i,
  input  logic  valid_i,
  input  work_t work_i,
  output logic  valid_o,
  output work_t work_o
);

  work_t work_d;
  work_t work_q;
  logic  valid_q;

  always_comb begin
    logic [SUM_W:0] trial;
    logic [SUM_W:0] div;
    logic [SUM_W:0] diff;
    logic           ge;
    trial  = '0;
    div    = '0;
    diff   = '0;
    ge     = 1'b0;
    work_d = work_i;
    for (int i = 0; i < NUM_CMDS; i++) begin
      trial = {work_i.lane[i].rem, 1'b0};
      div   = {1'b0, work_i.grp[ATT_LANES[i]].sum};
      diff  = trial - div;
      ge    = (trial >= div);
      // The remainder stays below the sum, so it fits back into SUM_W bits.
      work_d.lane[i].rem = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      work_d.lane[i].quo = {work_i.lane[i].quo[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

@@ rtl/core/glcn_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcn_back
// Output stage: applies the sign to each quotient, saturates, picks between
// scaled, unchanged and zero results, and holds the output register.
// ----------------------------------------------------------------------------
module glcn_back import glcn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  logic     valid_i,
  input  work_t    work_i,
  output logic     valid_o,
  output cmd_out_t data_o
);

  cmd_t     res [NUM_CMDS];
  cmd_out_t out_d;
  cmd_out_t out_q;
  logic     valid_q;

  always_comb begin
    wide_t ext;
    wide_t val;
    grp_t  grp;
    ext = '0;
    val = '0;
    grp = '0;
    for (int i = 0; i < NUM_CMDS; i++) begin
      grp = work_i.grp[ATT_LANES[i]];
      ext = wide_t'({1'b0, work_i.lane[i].quo});
      val = work_i.lane[i].raw[CMD_W-1] ? -ext : ext;
      if (grp.zero) begin
        res[i] = '0;
      end else if (grp.over) begin
        if (val > SAT_MAX) begin
          res[i] = SAT_MAX[CMD_W-1:0];
        end else if (val < SAT_MIN) begin
          res[i] = SAT_MIN[CMD_W-1:0];
        end else begin
          res[i] = val[CMD_W-1:0];
        end
      end else begin
        res[i] = work_i.lane[i].raw;
      end
    end
  end

  always_comb begin
    out_d.yaw_out   = res[LANE_YAW];
    out_d.roll_out  = res[LANE_ROLL];
    out_d.pitch_out = res[LANE_PITCH];
    out_d.x_out     = res[LANE_X];
    out_d.y_out     = res[LANE_Y];
    out_d.z_out     = res[LANE_Z];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = out_q;

endmodule

@@ rtl/core/grouped_l1_command_normalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_l1_command_normalizer
// Scales two groups of three Q3.12 motion commands so that each group's L1
// norm is at most 1.0, truncating the quotients toward zero.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while its output is not stalled. Each result
// passes through three front stages (magnitudes, group sums, the leading quotient
// bit), twelve divider stages that each develop one further quotient bit for all
// six commands, and the output register. When the output beat is not taken, the
// whole pipeline holds and the input side is not ready.
// There is no state between beats, and no wait after reset.
module grouped_l1_command_normalizer import glcn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cmd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cmd_out_t out_data_o
);

  logic  advance;
  logic  vld [FRAC_W+1];
  work_t wk  [FRAC_W+1];

  // The output register frees up when it is empty or its beat is taken.
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  glcn_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (in_valid_i),
    .data_i    (in_data_i),
    .valid_o   (vld[0]),
    .work_o    (wk[0])
  );

  for (genvar k = 0; k < FRAC_W; k++) begin : g_div
    glcn_div_step u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .valid_i   (vld[k]),
      .work_i    (wk[k]),
      .valid_o   (vld[k+1]),
      .work_o    (wk[k+1])
    );
  end

  glcn_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (vld[FRAC_W]),
    .work_i    (wk[FRAC_W]),
    .valid_o   (out_valid_o),
    .data_o    (out_data_o)
  );

`ifndef SYNTHESIS
  // A scaled member can never exceed 1.0 in magnitude.
  for (genvar i = 0; i < NUM_CMDS; i++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      vld[FRAC_W] && wk[FRAC_W].grp[ATT_LANES[i]].over
        |-> wk[FRAC_W].lane[i].quo <= ONE_QUO)
      else $error("quotient above 1.0 on lane %0d", i);

    // The final remainder must stay below the divisor.
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      vld[FRAC_W] && wk[FRAC_W].grp[ATT_LANES[i]].over
        |-> wk[FRAC_W].lane[i].rem < wk[FRAC_W].grp[ATT_LANES[i]].sum)
      else $error("division remainder not reduced on lane %0d", i);
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[FRAC_W] && advance && wk[FRAC_W].grp[GRP_PLANAR].zero
      |=> out_data_o.yaw_out == '0 && out_data_o.x_out == '0
          && out_data_o.y_out == '0)
    else $error("zero planar sum did not give zero outputs");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[FRAC_W] && advance && wk[FRAC_W].grp[GRP_ATT].zero
      |=> out_data_o.roll_out == '0 && out_data_o.pitch_out == '0
          && out_data_o.z_out == '0)
    else $error("zero attitude sum did not give zero outputs");
`endif

endmodule

@@ sim/tb_grouped_l1_command_normalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grouped_l1_command_normalizer
// Self-checking bench for the grouped L1 command normalizer. Command beats are
// queued by the stimulus process and played out by a clocked driver. Each
// accepted beat is run through a behavioral normalizer, and the result is
// queued. A clocked monitor checks every result beat against that queue, field
// by field. Both sides idle at random, and the run includes a no-idle stretch,
// a long receiver stall and a full drain of the pipeline.
// ----------------------------------------------------------------------------
module tb_grouped_l1_command_normalizer;
  import glcn_pkg::*;

  localparam int IDLE_PCT  = 37;
  localparam int STALL_LEN = 200;
  localparam int TAIL_CYC  = 40;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready_o;
  cmd_in_t  in_data   = '0;
  logic     out_valid_o;
  logic     out_ready = 1'b0;
  cmd_out_t out_data_o;

  cmd_in_t  pending_q[$];
  cmd_out_t expected_q[$];
  int       mismatch_count = 0;

  // Knobs set by the stimulus process on the falling edge; stall_done and stall_left are kept by the monitor.
  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;
  bit stall_req  = 1'b0;
  bit stall_done = 1'b0;
  int stall_left = 0;

  grouped_l1_command_normalizer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic longint cmd_mag(input cmd_t v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  function automatic cmd_t scale_cmd(input cmd_t v, input longint grp_sum);
    longint one_val;
    longint lim_hi;
    longint lim_lo;
    longint q;
    one_val = longint'(1) << FRAC_W;
    lim_hi  = (longint'(1) << (CMD_W - 1)) - 1;
    lim_lo  = -lim_hi - 1;
    if (grp_sum == 0) return '0;
    if (grp_sum <= one_val) return v;
    // Divide the magnitude so the quotient truncates toward zero.
    q = (cmd_mag(v) << FRAC_W) / grp_sum;
    if (v < 0) q = -q;
    if (q > lim_hi) q = lim_hi;
    else if (q < lim_lo) q = lim_lo;
    return cmd_t'(q);
  endfunction

  function automatic cmd_out_t normalize_cmds(input cmd_in_t c);
    cmd_out_t r;
    longint   planar_sum;
    longint   att_sum;
    planar_sum = cmd_mag(c.yaw_cmd) + cmd_mag(c.x_cmd) + cmd_mag(c.y_cmd);
    att_sum    = cmd_mag(c.roll_cmd) + cmd_mag(c.pitch_cmd) + cmd_mag(c.z_cmd);
    r.yaw_out   = scale_cmd(c.yaw_cmd, planar_sum);
    r.x_out     = scale_cmd(c.x_cmd, planar_sum);
    r.y_out     = scale_cmd(c.y_cmd, planar_sum);
    r.roll_out  = scale_cmd(c.roll_cmd, att_sum);
    r.pitch_out = scale_cmd(c.pitch_cmd, att_sum);
    r.z_out     = scale_cmd(c.z_cmd, att_sum);
    return r;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t v;
    case ($urandom_range(4))
      0, 1: v = cmd_t'($urandom);
      2: v = cmd_t'($urandom_range(2800));
      3: v = cmd_t'($urandom_range(15));
      default: begin
        case ($urandom_range(5))
          0: v = 16'sh8000;
          1: v = 16'sh7FFF;
          2: v = '0;
          3: v = -16'sd1;
          4: v = 16'sd4096;
          default: v = -16'sd4096;
        endcase
      end
    endcase
    if ($urandom_range(1) != 0) v = -v;
    return v;
  endfunction

  task automatic push_cmds(input int yaw, input int roll, input int pitch,
                           input int x, input int y, input int z);
    cmd_in_t c;
    c.yaw_cmd   = cmd_t'(yaw);
    c.roll_cmd  = cmd_t'(roll);
    c.pitch_cmd = cmd_t'(pitch);
    c.x_cmd     = cmd_t'(x);
    c.y_cmd     = cmd_t'(y);
    c.z_cmd     = cmd_t'(z);
    pending_q.push_back(c);
  endtask

  task automatic push_random(input int n);
    cmd_in_t c;
    repeat (n) begin
      c.yaw_cmd   = rand_cmd();
      c.roll_cmd  = rand_cmd();
      c.pitch_cmd = rand_cmd();
      c.x_cmd     = rand_cmd();
      c.y_cmd     = rand_cmd();
      c.z_cmd     = rand_cmd();
      // Now and then one group is silent so the zero-sum path gets traffic.
      if ($urandom_range(9) == 0) begin
        c.yaw_cmd = '0;
        c.x_cmd   = '0;
        c.y_cmd   = '0;
      end
      if ($urandom_range(9) == 0) begin
        c.roll_cmd  = '0;
        c.pitch_cmd = '0;
        c.z_cmd     = '0;
      end
      pending_q.push_back(c);
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic check_lane(input string lane, input cmd_t want, input cmd_t got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", lane, want, got);
      mismatch_count++;
    end
  endtask

  // Command driver: one beat offered at a time, held until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    logic taken;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && in_ready_o;
      if (taken) expected_q.push_back(normalize_cmds(in_data));
      if (!in_valid || taken) begin
        if (pending_q.size() != 0 && (tx_no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    cmd_out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no command pending: %h", out_data_o);
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          check_lane("yaw_out", want.yaw_out, out_data_o.yaw_out);
          check_lane("roll_out", want.roll_out, out_data_o.roll_out);
          check_lane("pitch_out", want.pitch_out, out_data_o.pitch_out);
          check_lane("x_out", want.x_out, out_data_o.x_out);
          check_lane("y_out", want.y_out, out_data_o.y_out);
          check_lane("z_out", want.z_out, out_data_o.z_out);
        end
      end
      if (stall_req && !stall_done) begin
        stall_left = STALL_LEN;
        stall_done = 1'b1;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rx_no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, exact 1.0 sums, just-over sums, zero groups.
    push_cmds(0, 0, 0, 0, 0, 0);
    push_cmds(32767, 32767, 32767, 32767, 32767, 32767);
    push_cmds(-32768, -32768, -32768, -32768, -32768, -32768);
    push_cmds(-32768, 32767, -32768, 32767, -32768, 32767);
    push_cmds(4096, 2048, -2048, 0, 0, 0);
    push_cmds(4097, 2049, -2048, 0, 0, 0);
    push_cmds(1365, -1, -1, 1365, 1366, -4094);
    push_cmds(1, -1, 1, -1, 1, -1);
    push_cmds(-32768, 32767, 0, 0, 0, -32768);
    push_cmds(0, 100, 200, 0, 0, -300);
    push_cmds(30000, 0, 0, -20000, 5, 0);
    push_cmds(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    push_cmds(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    push_cmds(-1, -1, -1, -1, -1, -1);
    push_cmds(32767, -32768, 32767, -32768, 32767, -32768);
    push_cmds(-3, 4096, 3, 4096, 0, 0);
    push_cmds(-4096, 0, 0, 0, 0, -4096);
    push_cmds(4095, 4096, 1, 1, 0, -1);
    push_cmds(-32768, 0, 0, 0, 0, 0);
    push_cmds(0, -32768, 0, 0, 0, 0);
    // Sender waits here until the pipeline has fully drained.
    wait_drained();

    push_random(300);

    // No idling on either side.
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    push_random(200);
    while (pending_q.size() != 0) @(negedge clk_i);
    rx_no_idle = 1'b0;

    // Long receiver stall while the sender keeps offering beats.
    stall_req = 1'b1;
    push_random(200);
    while (pending_q.size() != 0) @(negedge clk_i);
    tx_no_idle = 1'b0;

    push_random(180);
    wait_drained();
    repeat (TAIL_CYC) @(negedge clk_i);

    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/glcn_pkg.sv
rtl/core/glcn_front.sv
rtl/core/glcn_div_step.sv
rtl/core/glcn_back.sv
rtl/core/grouped_l1_command_normalizer.sv
sim/tb_grouped_l1_command_normalizer.sv
